// ----- rtl/core/gsm_pkg.sv -----
// shared types, field widths and default sizes for the generational slot map
package gsm_pkg;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_STALE = 2'd3
    } status_t;

    // fixed field widths of the stream payloads
    localparam int REQ_W       = 2;
    localparam int IDX_FIELD_W = 8;
    localparam int GEN_FIELD_W = 16;
    localparam int REF_FIELD_W = 32;
    localparam int STATUS_W    = 2;

    // packed stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_PAD_W  = OUT_DATA_W - (STATUS_W + IDX_FIELD_W + GEN_FIELD_W
                                              + REF_FIELD_W + 1);

    // default store geometry
    localparam int SLOTS_DEF    = 256;
    localparam int GEN_BITS_DEF = 16;
    localparam int REF_BITS_DEF = 32;

endpackage

// ----- rtl/core/generational_slot_map.sv -----
// generational handle allocator over a fixed slot store, with lifo free stack
//
//  channel   | signals                              | contents (low bits first)
//  ----------+--------------------------------------+-------------------------------------
//  s_axis    | tvalid tready tdata[55:0] tuser[1:0] | data: slot_index, handle_gen,
//            |                                      | object_ref; user: req_type
//  m_axis    | tvalid tready tdata[63:0]            | status, out_index, out_gen,
//            |                                      | out_ref, needs_sort, zero pad
//
// one transaction per cycle sustained while the result side is not stalled; the
// request stage registers the request and reads the slot, payload and stack memories,
// then the commit step checks the handle, writes the memories back and loads the result
// register, with same-cycle writes bypassed into the next reads
// reset clears only the counters, dirty flag and valid flags; no clearing pass
// a stalled result holds the request stage, which then holds the input side
module generational_slot_map #(
    parameter int SLOTS    = gsm_pkg::SLOTS_DEF,
    parameter int GEN_BITS = gsm_pkg::GEN_BITS_DEF,
    parameter int REF_BITS = gsm_pkg::REF_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot_index[7:0], handle_gen[23:8], object_ref[55:24]
    input  logic [gsm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[1:0]
    input  logic [gsm_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], out_index[9:2], out_gen[25:10], out_ref[57:26], needs_sort[58]
    output logic [gsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > gsm_pkg::IDX_FIELD_W) ? CNT_W : gsm_pkg::IDX_FIELD_W;
    localparam int GCMP_W = (GEN_BITS > gsm_pkg::GEN_FIELD_W) ? GEN_BITS
                                                              : gsm_pkg::GEN_FIELD_W;
    localparam int STK_W  = IDX_W + GEN_BITS;
    localparam int META_W = GEN_BITS + 1;

    // input field positions
    localparam int IN_IDX_LSB = 0;
    localparam int IN_GEN_LSB = IN_IDX_LSB + gsm_pkg::IDX_FIELD_W;
    localparam int IN_REF_LSB = IN_GEN_LSB + gsm_pkg::GEN_FIELD_W;

    // memories: slot meta {live, generation}, payload, free stack {index, generation}
    logic [META_W-1:0]   meta_mem [SLOTS];
    logic [REF_BITS-1:0] pay_mem  [SLOTS];
    logic [STK_W-1:0]    stk_mem  [SLOTS];

    // request stage
    logic                               s1_valid_reg;
    gsm_pkg::req_t                      s1_req_reg;
    logic [gsm_pkg::IDX_FIELD_W-1:0]    s1_idx_reg;
    logic [gsm_pkg::GEN_FIELD_W-1:0]    s1_gen_reg;
    logic [gsm_pkg::REF_FIELD_W-1:0]    s1_ref_reg;
    logic [META_W-1:0]                  meta_q_reg;
    logic [REF_BITS-1:0]                pay_q_reg;
    logic [STK_W-1:0]                   stk_q_reg;

    // map state
    logic [CNT_W-1:0]                   free_count_reg, free_count_next;
    logic [CNT_W-1:0]                   used_slots_reg, used_slots_next;
    logic                               dirty_reg, dirty_next;

    // result register
    logic                               m_valid_reg, m_valid_next;
    logic [gsm_pkg::OUT_DATA_W-1:0]     m_data_reg;

    // handshake and stage advance
    logic s_accept;
    logic s1_advance;

    // memory write ports and read addresses
    logic                meta_we;
    logic [IDX_W-1:0]    meta_wa;
    logic [META_W-1:0]   meta_wd;
    logic                pay_we;
    logic [IDX_W-1:0]    pay_wa;
    logic [REF_BITS-1:0] pay_wd;
    logic                stk_we;
    logic [IDX_W-1:0]    stk_wa;
    logic [STK_W-1:0]    stk_wd;
    logic [IDX_W-1:0]    rd_slot_addr;
    logic [IDX_W-1:0]    rd_stk_addr;
    logic [CNT_W-1:0]    fc_after;

    // handle check and result fields
    logic                meta_live;
    logic [GEN_BITS-1:0] meta_gen;
    logic [GEN_BITS-1:0] gen_bumped;
    gsm_pkg::status_t    chk_status;
    gsm_pkg::status_t    res_status;
    logic [IDX_W-1:0]    res_idx;
    logic [GEN_BITS-1:0] res_gen;
    logic [REF_BITS-1:0] res_ref;

    assign s1_advance    = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // read addresses: slot from the incoming index, stack top after this cycle's commit
    assign fc_after     = s1_advance ? free_count_next : free_count_reg;
    assign rd_slot_addr = IDX_W'(s_axis_tdata[IN_IDX_LSB +: gsm_pkg::IDX_FIELD_W]);
    assign rd_stk_addr  = IDX_W'(fc_after - CNT_W'(1));

    // handle check against the slot meta read for this request
    assign meta_live  = meta_q_reg[GEN_BITS];
    assign meta_gen   = meta_q_reg[GEN_BITS-1:0];
    assign gen_bumped = meta_gen + GEN_BITS'(1);

    always_comb
    begin
        if (CMP_W'(s1_idx_reg) >= CMP_W'(used_slots_reg))
        begin
            chk_status = gsm_pkg::ST_RANGE;
        end
        else if ((GCMP_W'(meta_gen) != (GCMP_W'(s1_gen_reg) & GCMP_W'({GEN_BITS{1'b1}})))
                 || !meta_live)
        begin
            chk_status = gsm_pkg::ST_STALE;
        end
        else
        begin
            chk_status = gsm_pkg::ST_OK;
        end
    end

    // request execution: next state, memory writes and result fields
    always_comb
    begin
        free_count_next = free_count_reg;
        used_slots_next = used_slots_reg;
        dirty_next      = dirty_reg;
        meta_we         = 1'b0;
        meta_wa         = '0;
        meta_wd         = '0;
        pay_we          = 1'b0;
        pay_wa          = '0;
        pay_wd          = '0;
        stk_we          = 1'b0;
        stk_wa          = IDX_W'(free_count_reg);
        stk_wd          = '0;
        res_status      = gsm_pkg::ST_OK;
        res_idx         = '0;
        res_gen         = '0;
        res_ref         = '0;
        case (s1_req_reg)
            gsm_pkg::REQ_ALLOC:
            begin
                if (free_count_reg != '0)
                begin
                    // reuse the most recently freed slot
                    free_count_next = free_count_reg - CNT_W'(1);
                    res_idx         = stk_q_reg[STK_W-1:GEN_BITS];
                    res_gen         = stk_q_reg[GEN_BITS-1:0];
                end
                else if (used_slots_reg < CNT_W'(SLOTS))
                begin
                    // fresh slot, generation starts at zero
                    used_slots_next = used_slots_reg + CNT_W'(1);
                    res_idx         = IDX_W'(used_slots_reg);
                    res_gen         = '0;
                end
                else
                begin
                    res_status = gsm_pkg::ST_FULL;
                end
                if (res_status == gsm_pkg::ST_OK)
                begin
                    meta_we    = 1'b1;
                    meta_wa    = res_idx;
                    meta_wd    = {1'b1, res_gen};
                    pay_we     = 1'b1;
                    pay_wa     = res_idx;
                    pay_wd     = REF_BITS'(s1_ref_reg);
                    dirty_next = 1'b1;
                end
            end
            gsm_pkg::REQ_FREE:
            begin
                res_status = chk_status;
                if (chk_status == gsm_pkg::ST_OK && free_count_reg < CNT_W'(SLOTS))
                begin
                    meta_we         = 1'b1;
                    meta_wa         = IDX_W'(s1_idx_reg);
                    meta_wd         = {1'b0, gen_bumped};
                    pay_we          = 1'b1;
                    pay_wa          = IDX_W'(s1_idx_reg);
                    pay_wd          = '0;
                    stk_we          = 1'b1;
                    stk_wd          = {IDX_W'(s1_idx_reg), gen_bumped};
                    free_count_next = free_count_reg + CNT_W'(1);
                    dirty_next      = 1'b1;
                end
            end
            gsm_pkg::REQ_LOOKUP:
            begin
                res_status = chk_status;
                if (chk_status == gsm_pkg::ST_OK)
                begin
                    res_ref = pay_q_reg;
                end
            end
            gsm_pkg::REQ_CLEAR:
            begin
                dirty_next = 1'b0;
            end
            default:
            begin
                dirty_next = dirty_reg;
            end
        endcase
    end

    // slot meta memory, write-first bypass on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (s1_advance && meta_we)
        begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (s_accept)
        begin
            if (s1_advance && meta_we && meta_wa == rd_slot_addr)
            begin
                meta_q_reg <= meta_wd;
            end
            else
            begin
                meta_q_reg <= meta_mem[rd_slot_addr];
            end
        end
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (s1_advance && pay_we)
        begin
            pay_mem[pay_wa] <= pay_wd;
        end
        if (s_accept)
        begin
            if (s1_advance && pay_we && pay_wa == rd_slot_addr)
            begin
                pay_q_reg <= pay_wd;
            end
            else
            begin
                pay_q_reg <= pay_mem[rd_slot_addr];
            end
        end
    end

    // free stack memory, read at the top left by the committing request
    always_ff @(posedge clk)
    begin
        if (s1_advance && stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (s_accept)
        begin
            if (s1_advance && stk_we && stk_wa == rd_stk_addr)
            begin
                stk_q_reg <= stk_wd;
            end
            else
            begin
                stk_q_reg <= stk_mem[rd_stk_addr];
            end
        end
    end

    // request stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_req_reg <= gsm_pkg::req_t'(s_axis_tuser);
            s1_idx_reg <= s_axis_tdata[IN_IDX_LSB +: gsm_pkg::IDX_FIELD_W];
            s1_gen_reg <= s_axis_tdata[IN_GEN_LSB +: gsm_pkg::GEN_FIELD_W];
            s1_ref_reg <= s_axis_tdata[IN_REF_LSB +: gsm_pkg::REF_FIELD_W];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            m_data_reg <= {{gsm_pkg::OUT_PAD_W{1'b0}},
                           dirty_next,
                           gsm_pkg::REF_FIELD_W'(res_ref),
                           gsm_pkg::GEN_FIELD_W'(res_gen),
                           gsm_pkg::IDX_FIELD_W'(res_idx),
                           res_status};
        end
    end

    // control state
    assign m_valid_next = s1_advance || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            free_count_reg <= '0;
            used_slots_reg <= '0;
            dirty_reg      <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                free_count_reg <= free_count_next;
                used_slots_reg <= used_slots_next;
                dirty_reg      <= dirty_next;
            end
        end
    end

`ifndef SYNTHESIS
    // every stacked index is a slot handed out earlier
    a_stack_within_used: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= used_slots_reg)
        else $error("free stack deeper than slots handed out");

    // fresh slots never run past the store
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_slots_reg <= CNT_W'(SLOTS))
        else $error("used slot count beyond store size");

    // a full report stands only while no slot is left
    a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[gsm_pkg::STATUS_W-1:0] == gsm_pkg::ST_FULL)
        |-> (free_count_reg == '0 && used_slots_reg == CNT_W'(SLOTS)))
        else $error("store full reported with slots available");

    // map counters move only when a request commits
    a_state_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (free_count_reg != $past(free_count_reg) || used_slots_reg != $past(used_slots_reg))
        |-> $past(s1_advance))
        else $error("map counters changed without a committing request");
`endif

endmodule

// ----- verif/generational_slot_map_tb.sv -----
// self-checking testbench for the generational slot map: handle prediction, idle and stall phases

// one result transaction as seen on the master side
typedef struct {
    gsm_pkg::status_t status;
    logic [7:0]       slot;
    logic [15:0]      gen;
    logic [31:0]      obj;
    logic             sort;
} slot_result_t;

// handle allocator prediction and in-order result checking
class slot_map_scoreboard;
    logic [15:0]  gen_of     [gsm_pkg::SLOTS_DEF];
    logic [31:0]  payload_of [gsm_pkg::SLOTS_DEF];
    bit           live       [gsm_pkg::SLOTS_DEF];
    logic [7:0]   free_stack [gsm_pkg::SLOTS_DEF];
    int unsigned  free_count;
    int unsigned  used_slots;
    bit           dirty;
    slot_result_t pending[$];
    int unsigned  failures;
    int unsigned  results_seen;
    int unsigned  req_hits[4];
    int unsigned  status_hits[4];

    function new();
        free_count   = 0;
        used_slots   = 0;
        dirty        = 1'b0;
        failures     = 0;
        results_seen = 0;
        foreach (live[i])
            live[i] = 1'b0;
        foreach (req_hits[i])
        begin
            req_hits[i]    = 0;
            status_hits[i] = 0;
        end
    endfunction

    function bit store_full();
        return free_count == 0 && used_slots == gsm_pkg::SLOTS_DEF;
    endfunction

    // bound check first, then generation and occupancy
    function gsm_pkg::status_t handle_status(logic [7:0] idx, logic [15:0] g);
        if (idx >= used_slots)
            return gsm_pkg::ST_RANGE;
        if (gen_of[idx] != g || !live[idx])
            return gsm_pkg::ST_STALE;
        return gsm_pkg::ST_OK;
    endfunction

    // accepted request: update the predicted store and queue its result
    function void note_request(gsm_pkg::req_t kind, logic [7:0] idx, logic [15:0] g,
                               logic [31:0] obj);
        slot_result_t r;
        int unsigned  s;
        r.status = gsm_pkg::ST_OK;
        r.slot   = '0;
        r.gen    = '0;
        r.obj    = '0;
        s        = 0;
        req_hits[kind]++;
        case (kind)
            gsm_pkg::REQ_ALLOC:
            begin
                if (free_count > 0)
                begin
                    free_count--;
                    s = free_stack[free_count];
                end
                else if (used_slots < gsm_pkg::SLOTS_DEF)
                begin
                    s = used_slots;
                    gen_of[s] = '0;
                    used_slots++;
                end
                else
                    r.status = gsm_pkg::ST_FULL;
                if (r.status == gsm_pkg::ST_OK)
                begin
                    payload_of[s] = obj;
                    live[s]       = 1'b1;
                    dirty         = 1'b1;
                    r.slot        = s[7:0];
                    r.gen         = gen_of[s];
                end
            end
            gsm_pkg::REQ_FREE:
            begin
                r.status = handle_status(idx, g);
                if (r.status == gsm_pkg::ST_OK)
                begin
                    payload_of[idx]        = '0;
                    gen_of[idx]            = gen_of[idx] + 16'd1;
                    live[idx]              = 1'b0;
                    free_stack[free_count] = idx;
                    free_count++;
                    dirty = 1'b1;
                end
            end
            gsm_pkg::REQ_LOOKUP:
            begin
                r.status = handle_status(idx, g);
                if (r.status == gsm_pkg::ST_OK)
                    r.obj = payload_of[idx];
            end
            default:
                dirty = 1'b0;
        endcase
        r.sort = dirty;
        pending.insert(pending.size(), r);
    endfunction

    // accepted result: compare with the oldest expectation
    function void check_result(logic [63:0] d);
        slot_result_t want;
        slot_result_t got;
        got.status = gsm_pkg::status_t'(d[1:0]);
        got.slot   = d[9:2];
        got.gen    = d[25:10];
        got.obj    = d[57:26];
        got.sort   = d[58];
        results_seen++;
        if (pending.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected result transaction, tdata %h", d);
            return;
        end
        want = pending.pop_front();
        status_hits[want.status]++;
        if (got.status !== want.status || got.slot !== want.slot || got.gen !== want.gen
            || got.obj !== want.obj || got.sort !== want.sort)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("mismatch at result %0d: expected st %0d idx %0d gen %0d ref %h dirty %0d",
                         results_seen, want.status, want.slot, want.gen, want.obj, want.sort);
                $display("    actual st %0d idx %0d gen %0d ref %h dirty %0d",
                         got.status, got.slot, got.gen, got.obj, got.sort);
            end
        end
    endfunction

    // expectations still waiting at the end are failures
    function void flag_leftovers();
        if (pending.size() != 0)
        begin
            failures += pending.size();
            $display("%0d expected results never arrived", pending.size());
        end
    endfunction
endclass

module generational_slot_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [gsm_pkg::IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [gsm_pkg::REQ_W-1:0]       s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [gsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

    int                     idle_pct  = 0;
    int                     stall_pct = 0;
    slot_map_scoreboard     sb = new();

    generational_slot_map u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // one request transaction, with random idle cycles ahead of it
    task automatic send(input gsm_pkg::req_t kind, input logic [7:0] idx,
                        input logic [15:0] g, input logic [31:0] obj);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {obj, g, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(kind, idx, g, obj);
    endtask

    // hold off the sender until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // payloads with the extremes mixed in
    function automatic logic [31:0] random_obj();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        return $urandom;
    endfunction

    // random slot below the high-water mark that is live or vacant, -1 if none
    function automatic int pick_slot(input bit want_live);
        int start;
        int s;
        if (sb.used_slots == 0)
            return -1;
        start = $urandom_range(sb.used_slots - 1);
        for (int i = 0; i < sb.used_slots; i++)
        begin
            s = (start + i) % sb.used_slots;
            if (sb.live[s] == want_live)
                return s;
        end
        return -1;
    endfunction

    // mostly well-formed handle traffic, some broken handles and noise
    task automatic random_request();
        int            k;
        int            s;
        gsm_pkg::req_t kind;
        logic [15:0]   g;
        k    = $urandom_range(99);
        kind = ($urandom_range(1) == 0) ? gsm_pkg::REQ_FREE : gsm_pkg::REQ_LOOKUP;
        if (k < 35 || (k < 86 && pick_slot(1'b1) < 0))
            send(gsm_pkg::REQ_ALLOC, 8'($urandom), 16'($urandom), random_obj());
        else if (k < 60)
        begin
            s = pick_slot(1'b1);
            send(gsm_pkg::REQ_FREE, s[7:0], sb.gen_of[s], $urandom);
        end
        else if (k < 80)
        begin
            s = pick_slot(1'b1);
            send(gsm_pkg::REQ_LOOKUP, s[7:0], sb.gen_of[s], $urandom);
        end
        else if (k < 86)
        begin
            // vacant slot with its current generation, else a live one with a wrong one
            s = pick_slot(1'b0);
            if (s >= 0 && $urandom_range(1) == 0)
                g = sb.gen_of[s];
            else
            begin
                s = pick_slot(1'b1);
                g = sb.gen_of[s] ^ 16'($urandom_range(65535, 1));
            end
            send(kind, s[7:0], g, $urandom);
        end
        else if (k < 92 && sb.used_slots < gsm_pkg::SLOTS_DEF)
            send(kind, 8'($urandom_range(gsm_pkg::SLOTS_DEF - 1, sb.used_slots)),
                 16'($urandom), $urandom);
        else if (k < 96)
            send(gsm_pkg::REQ_CLEAR, 8'($urandom), 16'($urandom), $urandom);
        else
            send(gsm_pkg::req_t'($urandom_range(3)), 8'($urandom), 16'($urandom), $urandom);
    endtask

    // short directed sequence over every request kind and the range and stale error paths
    task automatic directed_requests();
        send(gsm_pkg::REQ_LOOKUP, 8'd0,   16'd0,    32'h1234_5678);
        send(gsm_pkg::REQ_FREE,   8'd255, 16'hffff, 32'hffff_ffff);
        send(gsm_pkg::REQ_CLEAR,  8'd0,   16'd0,    32'd0);
        send(gsm_pkg::REQ_ALLOC,  8'hff,  16'hffff, 32'd0);
        send(gsm_pkg::REQ_ALLOC,  8'd0,   16'd0,    32'hffff_ffff);
        send(gsm_pkg::REQ_ALLOC,  8'd0,   16'd0,    $urandom);
        send(gsm_pkg::REQ_LOOKUP, 8'd0,   16'd0,    32'd0);
        send(gsm_pkg::REQ_LOOKUP, 8'd1,   16'd0,    32'd0);
        send(gsm_pkg::REQ_LOOKUP, 8'd1,   16'hffff, 32'd0);
        send(gsm_pkg::REQ_CLEAR,  8'hff,  16'hffff, 32'hffff_ffff);
        // failed free must not set dirty
        send(gsm_pkg::REQ_FREE,   8'd1,   16'd1,    32'd0);
        send(gsm_pkg::REQ_FREE,   8'd1,   16'd0,    32'd0);
        // double free and vacant slot with matching generation
        send(gsm_pkg::REQ_FREE,   8'd1,   16'd0,    32'd0);
        send(gsm_pkg::REQ_FREE,   8'd1,   16'd1,    32'd0);
        send(gsm_pkg::REQ_LOOKUP, 8'd1,   16'd1,    32'd0);
        send(gsm_pkg::REQ_FREE,   8'd3,   16'd0,    32'd0);
        send(gsm_pkg::REQ_FREE,   8'd2,   16'd0,    32'd0);
        // lifo reuse, then a fresh slot
        send(gsm_pkg::REQ_ALLOC,  8'd0,   16'd0,    32'h8000_0001);
        send(gsm_pkg::REQ_ALLOC,  8'd0,   16'd0,    32'h0000_0001);
        send(gsm_pkg::REQ_ALLOC,  8'd0,   16'd0,    32'hdead_beef);
        send(gsm_pkg::REQ_LOOKUP, 8'd2,   16'd1,    32'd0);
        send(gsm_pkg::REQ_CLEAR,  8'd0,   16'd0,    32'd0);
        send(gsm_pkg::REQ_CLEAR,  8'd0,   16'd0,    32'd0);
    endtask

    // fill every slot, then knock on the full store
    task automatic fill_store();
        while (!sb.store_full())
            send(gsm_pkg::REQ_ALLOC, 8'($urandom), 16'($urandom), random_obj());
        repeat (3)
            send(gsm_pkg::REQ_ALLOC, 8'($urandom), 16'($urandom), random_obj());
        send(gsm_pkg::REQ_LOOKUP, 8'd255, sb.gen_of[255], $urandom);
    endtask

    // cycle one slot through repeated free and reuse, generation climbing each round
    task automatic reuse_slot();
        int s;
        if (pick_slot(1'b1) < 0)
            send(gsm_pkg::REQ_ALLOC, '0, '0, random_obj());
        s = pick_slot(1'b1);
        send(gsm_pkg::REQ_FREE, s[7:0], sb.gen_of[s], '0);
        repeat (16)
        begin
            send(gsm_pkg::REQ_ALLOC, 8'($urandom), 16'($urandom), random_obj());
            send(gsm_pkg::REQ_FREE, s[7:0], sb.gen_of[s], $urandom);
        end
        send(gsm_pkg::REQ_ALLOC, '0, '0, random_obj());
        send(gsm_pkg::REQ_LOOKUP, s[7:0], sb.gen_of[s], '0);
    endtask

    // run timeout
    initial
    begin
        #5_000_000;
        $display("generational_slot_map verification failed");
        $finish;
    end

    // stimulus phases
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no idling: directed then random
        directed_requests();
        repeat (120) random_request();
        drain();

        // sender idle most cycles
        idle_pct = 75;
        repeat (150) random_request();
        drain();

        // receiver stalling most cycles, store driven full
        idle_pct  = 0;
        stall_pct = 75;
        fill_store();
        repeat (90) random_request();
        drain();

        // light idling on both sides
        idle_pct  = 19;
        stall_pct = 19;
        repeat (130) random_request();
        drain();

        // back to back, one slot reused over and over
        idle_pct  = 0;
        stall_pct = 0;
        reuse_slot();
        drain();

        repeat (8) @(posedge clk);
        sb.flag_leftovers();
        $display("covered %0d requests: alloc %0d, free %0d, lookup %0d, clear %0d",
                 sb.req_hits[gsm_pkg::REQ_ALLOC] + sb.req_hits[gsm_pkg::REQ_FREE]
                 + sb.req_hits[gsm_pkg::REQ_LOOKUP] + sb.req_hits[gsm_pkg::REQ_CLEAR],
                 sb.req_hits[gsm_pkg::REQ_ALLOC], sb.req_hits[gsm_pkg::REQ_FREE],
                 sb.req_hits[gsm_pkg::REQ_LOOKUP], sb.req_hits[gsm_pkg::REQ_CLEAR]);
        $display("%0d results checked: ok %0d, full %0d, range %0d, stale %0d; failures %0d",
                 sb.results_seen, sb.status_hits[gsm_pkg::ST_OK],
                 sb.status_hits[gsm_pkg::ST_FULL], sb.status_hits[gsm_pkg::ST_RANGE],
                 sb.status_hits[gsm_pkg::ST_STALE], sb.failures);
        if (sb.failures == 0)
            $display("generational_slot_map verification clean");
        else
            $display("generational_slot_map verification failed");
        $finish;
    end

endmodule
